// ===== hw/rtl/hcsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hyperbolic CORDIC sinh/cosh package
// Shared widths, register indexes, the data type carried through the pipeline
// and the elaboration-time functions for the stage schedule and angle table.
// ----------------------------------------------------------------------------
package hcsc_pkg;

	localparam int DATA_W          = 32;
	localparam int CNT_W           = 6;
	localparam int INITX_W         = 31;
	localparam int CFG_IDX_W       = 1;
	localparam int ITER_MAX_DEF    = 32;
	localparam int FRAC_BITS_DEF   = 28;
	localparam int ITER_LIMIT      = 32;
	localparam int WORK_FRAC       = 62;

	localparam logic [CNT_W-1:0]   COUNT_RST = 6'd32;
	localparam logic [INITX_W-1:0] INITX_RST = 31'd324135026;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ITER_COUNT = 1'b0,
		CFG_INITIAL_X  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] z;
	} hcsc_item_t;

	// Number of micro-steps: one per iteration plus one per repeated iteration.
	function automatic int num_stages(input int iter_max);
		int cnt;
		int rep;
		cnt = 0;
		rep = 4;
		for (int k = 1; k < ITER_LIMIT; k++) begin
			if (k < iter_max) begin
				cnt = cnt + 1;
				if (k == rep) begin
					cnt = cnt + 1;
					rep = 3 * rep + 1;
				end
			end
		end
		return cnt;
	endfunction

	// Iteration index k carried out by micro-step j.
	function automatic int stage_k(input int j);
		int idx;
		int rep;
		int res;
		idx = 0;
		rep = 4;
		res = 1;
		for (int k = 1; k < ITER_LIMIT; k++) begin
			if (idx == j) begin
				res = k;
			end
			idx = idx + 1;
			if (k == rep) begin
				if (idx == j) begin
					res = k;
				end
				idx = idx + 1;
				rep = 3 * rep + 1;
			end
		end
		return res;
	endfunction

	// Shift-subtract long division, used only on constants at elaboration.
	function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atanh(2^-k) rounded to nearest at frac fraction bits.
	function automatic logic [DATA_W-1:0] atanh_entry(input int k, input int frac);
		logic [63:0] sum;
		int          e;
		sum = '0;
		for (int m = 0; m < 32; m++) begin
			e = k * (2 * m + 1);
			if (e <= WORK_FRAC) begin
				sum = sum + const_udiv(64'd1 << (WORK_FRAC - e), 64'(2 * m + 1));
			end
		end
		sum = sum + (64'd1 << (WORK_FRAC - frac - 1));
		sum = sum >> (WORK_FRAC - frac);
		return sum[DATA_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/hcsc_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hyperbolic CORDIC micro-step
// One registered rotation step with a fixed shift and angle constant. The step
// is bypassed when its iteration index is not below the active count.
// ----------------------------------------------------------------------------
module hcsc_stage
	import hcsc_pkg::*;
#(
	parameter int K         = 1,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [CNT_W-1:0] count,
	input  logic             in_valid,
	input  hcsc_item_t       in_item,
	output logic             out_valid,
	output hcsc_item_t       out_item
);

	localparam logic [DATA_W-1:0] ANGLE = atanh_entry(K, FRAC_BITS);
	localparam logic [CNT_W-1:0]  K_IDX = CNT_W'(K);

	logic              valid_s1;
	hcsc_item_t        item_s1;
	hcsc_item_t        next_item;
	logic [DATA_W-1:0] xs;
	logic [DATA_W-1:0] ys;
	logic              active;

	assign active = (K_IDX < count);
	assign xs     = DATA_W'($signed(in_item.x) >>> K);
	assign ys     = DATA_W'($signed(in_item.y) >>> K);

	always_comb begin
		next_item = in_item;
		if (active) begin
			if (!in_item.z[DATA_W-1]) begin
				next_item.x = in_item.x + ys;
				next_item.y = in_item.y + xs;
				next_item.z = in_item.z - ANGLE;
			end else begin
				next_item.x = in_item.x - ys;
				next_item.y = in_item.y - xs;
				next_item.z = in_item.z + ANGLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= next_item;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

// ===== hw/rtl/hcsc_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hyperbolic CORDIC output buffer
// Output register plus one skid entry, so the pipeline enable comes from a
// register and never from the downstream ready.
// ----------------------------------------------------------------------------
module hcsc_skid
	import hcsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [2*DATA_W-1:0] in_data,
	output logic                in_ready,
	output logic                out_valid,
	output logic [2*DATA_W-1:0] out_data,
	input  logic                out_ready
);

	logic                out_valid_q;
	logic [2*DATA_W-1:0] out_data_q;
	logic                skid_valid_q;
	logic [2*DATA_W-1:0] skid_data_q;
	logic                out_free;
	logic                accept;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (accept) begin
			skid_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== hw/rtl/hyperbolic_cordic_sinh_cosh_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hyperbolic CORDIC sinh/cosh core
// Rotation-mode hyperbolic CORDIC, one register stage per micro-step.
//
// Channel   Direction  Content
// s_axis    in         tdata[31:0] theta
// m_axis    out        tdata[31:0] sinh_out, tdata[63:32] cosh_out
// cfg       in         index 0 iteration_count, index 1 initial_x
//
// One transfer per cycle in each direction while no held output stalls the
// pipeline. A result passes the chain of stage registers and then the output
// register (iterations 4 and 13 use two stages each at ITER_MAX 32).
// Reset clears all valid bits and loads the register defaults.
// A held result keeps one more in the skid entry; then the pipeline stops.
// ----------------------------------------------------------------------------
module hyperbolic_cordic_sinh_cosh_core
	import hcsc_pkg::*;
#(
	parameter int ITER_MAX  = ITER_MAX_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] theta
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [2*DATA_W-1:0]  m_axis_tdata,   // [31:0] sinh_out, [63:32] cosh_out
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [INITX_W-1:0]   cfg_wdata
);

	localparam int NST = num_stages(ITER_MAX);

	logic [CNT_W-1:0]   count_q;
	logic [INITX_W-1:0] initx_q;
	logic [CNT_W-1:0]   count_eff;
	logic               en;
	logic [NST:0]       stage_valid;
	hcsc_item_t         stage_item [NST+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RST;
			initx_q <= INITX_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ITER_COUNT: count_q <= cfg_wdata[CNT_W-1:0];
				CFG_INITIAL_X:  initx_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign count_eff = (count_q > CNT_W'(ITER_MAX)) ? CNT_W'(ITER_MAX) : count_q;

	assign stage_valid[0]  = s_axis_tvalid;
	assign stage_item[0].x = {1'b0, initx_q};
	assign stage_item[0].y = '0;
	assign stage_item[0].z = s_axis_tdata;
	assign s_axis_tready   = en;

	for (genvar j = 0; j < NST; j++) begin : g_stage
		hcsc_stage #(
			.K         (stage_k(j)),
			.FRAC_BITS (FRAC_BITS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.count     (count_eff),
			.in_valid  (stage_valid[j]),
			.in_item   (stage_item[j]),
			.out_valid (stage_valid[j+1]),
			.out_item  (stage_item[j+1])
		);
	end

	hcsc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stage_valid[NST]),
		.in_data   ({stage_item[NST].x, stage_item[NST].y}),
		.in_ready  (en),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_ready (m_axis_tready)
	);

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("pipeline stalled without a pending result");

	a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(stage_valid[NST:1]))
		else $error("pipeline valid bits moved during a stall");

	a_input_enters_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> stage_valid[1])
		else $error("accepted transfer did not enter the first stage");

endmodule

// ===== test/hyperbolic_cordic_sinh_cosh_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hyperbolic CORDIC sinh/cosh core testbench
// Streams angles through the core under several register settings and
// several patterns of idle and stall on both stream sides. A bit-exact
// rotation-mode CORDIC predictor in the testbench works out each sinh/cosh
// pair not given by a table row when an angle transfer is accepted. Result
// transfers are matched in order against the expected pairs, one field at a time.
// ----------------------------------------------------------------------------
module hyperbolic_cordic_sinh_cosh_core_tb;
	import hcsc_pkg::*;

	localparam int          FRAC          = FRAC_BITS_DEF;
	localparam int          STEPS_MAX     = ITER_MAX_DEF;
	localparam int          SETTLE_CYCLES = 40;
	localparam int          CYCLE_LIMIT   = 200000;
	localparam int          RANDOM_BLOCKS = 8;
	localparam int          BLOCK_ANGLES  = 60;
	localparam int          BURST_ANGLES  = 60;
	localparam int          MAX_PRINTS    = 40;
	localparam logic [31:0] ANGLE_LIM     = 32'h11E0_0000;
	localparam logic [31:0] ONE           = 32'h1000_0000;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [DATA_W-1:0] cosh_v;
		logic [DATA_W-1:0] sinh_v;
	} hyp_pair_t;

	typedef struct packed {
		logic [DATA_W-1:0] theta;
		hyp_pair_t         pair;
	} angle_job_t;

	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic [INITX_W-1:0] initx;
		logic [DATA_W-1:0]  theta;
		logic               typed;
		hyp_pair_t          pair;
	} angle_case_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [DATA_W-1:0]     s_axis_tdata;    // [31:0] theta
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [2*DATA_W-1:0]   m_axis_tdata;    // [31:0] sinh_out, [63:32] cosh_out
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [INITX_W-1:0]    cfg_wdata;

	logic [CNT_W-1:0]      count_reg;
	logic [INITX_W-1:0]    initx_reg;
	logic [DATA_W-1:0]     atanh_lut [1:31];
	angle_job_t            pending [$];
	angle_case_t           dir_table [$];

	int                    send_idle_pct;
	int                    recv_stall_pct;
	int                    hold_cycles;
	int                    err_cnt;
	int                    angles_sent;
	int                    results_seen;
	int                    reg_writes;
	int                    cycle_cnt;

	hyperbolic_cordic_sinh_cosh_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// atanh(2^-k) from its power series at 62 fraction bits, rounded to FRAC bits.
	function automatic logic [DATA_W-1:0] atanh_frac(input int k);
		logic [63:0] acc;
		int          e;
		acc = '0;
		for (int m = 0; m < 64; m++) begin
			e = k * (2 * m + 1);
			if (e <= 62)
				acc = acc + (64'd1 << (62 - e)) / 64'(2 * m + 1);
		end
		acc = acc + (64'd1 << (62 - FRAC - 1));
		acc = acc >> (62 - FRAC);
		return acc[DATA_W-1:0];
	endfunction

	function automatic hyp_pair_t cordic_predict(input logic [DATA_W-1:0] theta);
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] z;
		logic [DATA_W-1:0] xs;
		logic [DATA_W-1:0] ys;
		hyp_pair_t         res;
		int                n;
		int                rep;
		int                passes;
		x = {1'b0, initx_reg};
		y = '0;
		z = theta;
		n = (count_reg > STEPS_MAX) ? STEPS_MAX : int'(count_reg);
		rep = 4;
		for (int k = 1; k < n; k++) begin
			passes = (k == rep) ? 2 : 1;
			if (k == rep)
				rep = 3 * rep + 1;
			for (int p = 0; p < passes; p++) begin
				xs = $signed(x) >>> k;
				ys = $signed(y) >>> k;
				if (!z[DATA_W-1]) begin
					x = x + ys;
					y = y + xs;
					z = z - atanh_lut[k];
				end else begin
					x = x - ys;
					y = y - xs;
					z = z + atanh_lut[k];
				end
			end
		end
		res.sinh_v = y;
		res.cosh_v = x;
		return res;
	endfunction

	function automatic logic [DATA_W-1:0] pick_angle();
		logic [DATA_W-1:0] a;
		case ($urandom_range(0, 9))
			7: a = $urandom;
			8: a = $signed($urandom_range(0, 511)) - 256;
			9: begin
				case ($urandom_range(0, 5))
					0: a = 32'h7FFF_FFFF;
					1: a = 32'h8000_0000;
					2: a = ANGLE_LIM;
					3: a = -ANGLE_LIM;
					4: a = ONE;
					default: a = '0;
				endcase
			end
			default: a = $urandom_range(0, 2 * ANGLE_LIM) - ANGLE_LIM;
		endcase
		return a;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] theta,
			input logic [DATA_W-1:0] got, input logic [DATA_W-1:0] want);
		err_cnt++;
		if (err_cnt <= MAX_PRINTS)
			$display("%0t ns: %s mismatch, theta %h: got %h, expected %h",
				$time, what, theta, got, want);
	endtask

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 76;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 76;
			end
			default: begin
				send_idle_pct = 7;
				recv_stall_pct = 7;
			end
		endcase
	endtask

	task automatic send_angle(input logic [DATA_W-1:0] theta, input logic typed,
			input hyp_pair_t typed_pair);
		angle_job_t job;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = theta;
		do @(posedge clk); while (!s_axis_tready);
		job.theta = theta;
		job.pair = typed ? typed_pair : cordic_predict(theta);
		pending.push_back(job);
		angles_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [INITX_W-1:0] value);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == CFG_ITER_COUNT)
			count_reg = value[CNT_W-1:0];
		else
			initx_reg = value;
		reg_writes++;
	endtask

	task automatic apply_config(input logic [CNT_W-1:0] count, input logic [INITX_W-1:0] initx);
		if (count != count_reg || initx != initx_reg) begin
			wait_drained();
			if (count != count_reg)
				write_reg(CFG_ITER_COUNT, INITX_W'(count));
			if (initx != initx_reg)
				write_reg(CFG_INITIAL_X, initx);
		end
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready = 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		hyp_pair_t  got;
		angle_job_t job;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", 'x, got.sinh_v, 'x);
			end else begin
				job = pending.pop_front();
				results_seen++;
				if (got.sinh_v !== job.pair.sinh_v)
					report_mismatch("sinh_out", job.theta, got.sinh_v, job.pair.sinh_v);
				if (got.cosh_v !== job.pair.cosh_v)
					report_mismatch("cosh_out", job.theta, got.cosh_v, job.pair.cosh_v);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_cnt, pending.size());
			$display("FAIL hyperbolic_cordic_sinh_cosh_core");
			$finish;
		end
	end

	initial begin
		logic [CNT_W-1:0]   rnd_count;
		logic [INITX_W-1:0] rnd_initx;
		angle_case_t        row;
		hyp_pair_t          no_pair;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_ITER_COUNT;
		cfg_wdata = '0;
		count_reg = COUNT_RST;
		initx_reg = INITX_RST;
		hold_cycles = 0;
		err_cnt = 0;
		angles_sent = 0;
		results_seen = 0;
		reg_writes = 0;
		cycle_cnt = 0;
		no_pair = '0;
		set_idle(IDLE_NONE);
		for (int k = 1; k <= 31; k++)
			atanh_lut[k] = atanh_frac(k);

		// count, initial x, theta, typed, {cosh, sinh}
		dir_table.push_back({COUNT_RST, INITX_RST, 32'h0000_0000, 1'b0, 64'd0});
		dir_table.push_back({COUNT_RST, INITX_RST, 32'h0000_0001, 1'b0, 64'd0});
		dir_table.push_back({COUNT_RST, INITX_RST, 32'hFFFF_FFFF, 1'b0, 64'd0});
		dir_table.push_back({COUNT_RST, INITX_RST, ONE, 1'b0, 64'd0});
		dir_table.push_back({COUNT_RST, INITX_RST, -ONE, 1'b0, 64'd0});
		dir_table.push_back({COUNT_RST, INITX_RST, 32'h0800_0000, 1'b0, 64'd0});
		dir_table.push_back({COUNT_RST, INITX_RST, ANGLE_LIM, 1'b0, 64'd0});
		dir_table.push_back({COUNT_RST, INITX_RST, -ANGLE_LIM, 1'b0, 64'd0});
		dir_table.push_back({COUNT_RST, INITX_RST, 32'h7FFF_FFFF, 1'b0, 64'd0});
		dir_table.push_back({COUNT_RST, INITX_RST, 32'h8000_0000, 1'b0, 64'd0});
		dir_table.push_back({6'd63, INITX_RST, ONE, 1'b0, 64'd0});
		dir_table.push_back({6'd63, INITX_RST, -ONE, 1'b0, 64'd0});
		dir_table.push_back({6'd33, INITX_RST, 32'h0C00_0000, 1'b0, 64'd0});
		dir_table.push_back({6'd2, INITX_RST, ONE, 1'b0, 64'd0});
		dir_table.push_back({6'd2, INITX_RST, -ONE, 1'b0, 64'd0});
		dir_table.push_back({6'd5, INITX_RST, 32'h0400_0000, 1'b0, 64'd0});
		dir_table.push_back({6'd14, INITX_RST, 32'h0900_0000, 1'b0, 64'd0});
		dir_table.push_back({6'd1, INITX_RST, 32'h8000_0000, 1'b1, {1'b0, INITX_RST}, 32'd0});
		dir_table.push_back({6'd1, 31'h7FFF_FFFF, 32'h1234_5678, 1'b1,
			32'h7FFF_FFFF, 32'd0});
		dir_table.push_back({6'd0, 31'd0, 32'h7FFF_FFFF, 1'b1, 64'd0});
		dir_table.push_back({6'd32, 31'd0, ONE, 1'b0, 64'd0});
		dir_table.push_back({6'd32, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 64'd0});
		dir_table.push_back({6'd32, 31'h7FFF_FFFF, ONE, 1'b0, 64'd0});

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_table[i]) begin
			row = dir_table[i];
			apply_config(row.count, row.initx);
			send_angle(row.theta, row.typed, row.pair);
		end
		wait_drained();

		// Receiver holds off while angles keep coming, so the pipeline backs up.
		apply_config(COUNT_RST, INITX_RST);
		set_idle(IDLE_NONE);
		@(posedge clk);
		hold_cycles = 300;
		@(negedge clk);
		for (int i = 0; i < BURST_ANGLES; i++)
			send_angle(pick_angle(), 1'b0, no_pair);
		wait_drained();

		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			if (blk == 0) begin
				rnd_count = COUNT_RST;
				rnd_initx = INITX_RST;
			end else begin
				case ($urandom_range(0, 5))
					0: rnd_count = COUNT_RST;
					1: rnd_count = CNT_W'($urandom_range(33, 63));
					2: rnd_count = CNT_W'($urandom_range(0, 1));
					default: rnd_count = CNT_W'($urandom_range(2, 31));
				endcase
				case ($urandom_range(0, 5))
					4: rnd_initx = INITX_W'($urandom);
					5: rnd_initx = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
					default: rnd_initx = INITX_RST;
				endcase
			end
			apply_config(rnd_count, rnd_initx);
			set_idle(idle_mode_t'(blk % 4));
			for (int i = 0; i < BLOCK_ANGLES; i++)
				send_angle(pick_angle(), 1'b0, no_pair);
		end
		wait_drained();

		$display("Covered %0d angles and %0d results over %0d register writes,",
			angles_sent, results_seen, reg_writes);
		$display("with idle, stall and backpressure phases; %0d mismatches.", err_cnt);
		if (err_cnt == 0 && pending.size() == 0)
			$display("PASS hyperbolic_cordic_sinh_cosh_core");
		else
			$display("FAIL hyperbolic_cordic_sinh_cosh_core");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/hcsc_pkg.sv
hw/rtl/hcsc_stage.sv
hw/rtl/hcsc_skid.sv
hw/rtl/hyperbolic_cordic_sinh_cosh_core.sv
test/hyperbolic_cordic_sinh_cosh_core_tb.sv
